FILE: rtl/ppci_pkg.sv
// Shared types, widths and the arctangent step table for the planar pose unit.
// Used by ppci_cordic_stage and planar_pose_compose_invert; depends on nothing.
package ppci_pkg;

    localparam int POS_W       = 32;   // Q16.16 position word
    localparam int ANGLE_BITS  = 16;   // one full turn = 2^ANGLE_BITS
    localparam int TRIG_FRAC   = 30;   // sine/cosine in Q2.30
    localparam int TRIG_W      = 34;   // CORDIC x/y width, headroom over Q2.30
    localparam int Z_W         = 33;   // residual angle, signed 32-bit binary angle sign-extended to 33 bits
    localparam int PROD_W      = TRIG_W + POS_W;
    localparam int SUM_W       = 64;
    localparam int RND_W       = SUM_W - TRIG_FRAC;
    localparam int TRIG_STAGES_DEF = 16;

    localparam int S_DATA_W = 160;     // six fields, already whole bytes
    localparam int M_DATA_W = 80;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // rotation vector plus residual angle, and the quadrant fold flag
    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic                     flip;
    } cordic_t;

    // operands that ride alongside the CORDIC
    typedef struct packed {
        logic                    invert;
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
        logic [ANGLE_BITS-1:0]   theta;
    } side_t;

endpackage

FILE: rtl/planar_pose_compose_invert.sv
// Planar pose unit top level: input register, CORDIC chain, multiply, sum, round/saturate.
// Depends on ppci_pkg and ppci_cordic_stage.
//
// Composes pose A with pose B (tuser 0) or inverts pose A (tuser 1). Fully
// pipelined: one transfer per cycle in and out while the output is not stalled;
// stages are the input register, one CORDIC step per stage, product stage, sum
// stage and output register. Each stage has its own valid bit and ready is chained
// back from the output, so a bubble anywhere is filled while the output is stalled.
// Positions are Q16.16 and clip to the 32-bit range with tuser set on output.
module planar_pose_compose_invert #(
    parameter int TRIG_STAGES = ppci_pkg::TRIG_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a_x, a_y, a_theta, b_x, b_y, b_theta
    input  logic [ppci_pkg::S_DATA_W-1:0] s_tdata,
    // action: 0 compose A then B, 1 invert A
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // r_x, r_y, r_theta
    output logic [ppci_pkg::M_DATA_W-1:0] m_tdata,
    // saturated
    output logic                          m_tuser
);
    import ppci_pkg::*;

    // ---------------- input register ----------------
    logic                  in_valid_reg, in_ready;
    cordic_t               in_vec_reg, in_vec_next;
    side_t                 in_side_reg, in_side_next;
    logic [31:0]           ang, ang_fold;
    logic                  flip;

    always_comb begin
        in_side_next.invert = s_tuser;
        in_side_next.ax     = s_tdata[31:0];
        in_side_next.ay     = s_tdata[63:32];
        in_side_next.bx     = s_tdata[111:80];
        in_side_next.by     = s_tdata[143:112];
        if (s_tuser) begin
            in_side_next.theta = ANGLE_BITS'(0) - s_tdata[79:64];
        end else begin
            in_side_next.theta = s_tdata[79:64] + s_tdata[159:144];
        end
    end

    // fold the left half-plane onto the right one, negate the results later
    assign ang      = {s_tdata[79:64], {(32-ANGLE_BITS){1'b0}}};
    assign flip     = ang[31] ^ ang[30];
    assign ang_fold = {ang[31] ^ flip, ang[30:0]};

    always_comb begin
        in_vec_next.x    = CORDIC_GAIN;
        in_vec_next.y    = '0;
        in_vec_next.z    = $signed({ang_fold[31], ang_fold});
        in_vec_next.flip = flip;
    end

    assign s_tready = !in_valid_reg || in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_vec_reg  <= in_vec_next;
            in_side_reg <= in_side_next;
        end
    end

    // ---------------- CORDIC chain ----------------
    logic    cv_valid [TRIG_STAGES+1];
    logic    cv_ready [TRIG_STAGES+1];
    cordic_t cv_vec   [TRIG_STAGES+1];
    side_t   cv_side  [TRIG_STAGES+1];

    assign cv_valid[0] = in_valid_reg;
    assign cv_vec[0]   = in_vec_reg;
    assign cv_side[0]  = in_side_reg;
    assign in_ready    = cv_ready[0];

    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cordic
        ppci_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv_valid[i]),
            .in_ready  (cv_ready[i]),
            .in_vec    (cv_vec[i]),
            .in_side   (cv_side[i]),
            .out_valid (cv_valid[i+1]),
            .out_ready (cv_ready[i+1]),
            .out_vec   (cv_vec[i+1]),
            .out_side  (cv_side[i+1])
        );
    end

    // ---------------- product stage ----------------
    logic                     mul_valid_reg, mul_ready, sum_ready;
    logic signed [PROD_W-1:0] pcx_reg, psy_reg, psx_reg, pcy_reg;
    side_t                    mul_side_reg;
    logic signed [TRIG_W-1:0] cos_v, sin_v, raw_x, raw_y;
    logic signed [POS_W-1:0]  px, py;

    assign raw_x = cv_vec[TRIG_STAGES].x;
    assign raw_y = cv_vec[TRIG_STAGES].y;
    assign cos_v = cv_vec[TRIG_STAGES].flip ? -raw_x : raw_x;
    assign sin_v = cv_vec[TRIG_STAGES].flip ? -raw_y : raw_y;
    assign px    = cv_side[TRIG_STAGES].invert ? cv_side[TRIG_STAGES].ax
                                               : cv_side[TRIG_STAGES].bx;
    assign py    = cv_side[TRIG_STAGES].invert ? cv_side[TRIG_STAGES].ay
                                               : cv_side[TRIG_STAGES].by;

    assign cv_ready[TRIG_STAGES] = mul_ready;
    assign mul_ready = !mul_valid_reg || sum_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            mul_valid_reg <= cv_valid[TRIG_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && cv_valid[TRIG_STAGES]) begin
            pcx_reg      <= cos_v * px;
            psy_reg      <= sin_v * py;
            psx_reg      <= sin_v * px;
            pcy_reg      <= cos_v * py;
            mul_side_reg <= cv_side[TRIG_STAGES];
        end
    end

    // ---------------- sum stage ----------------
    logic                     sum_valid_reg, out_ready;
    logic signed [SUM_W-1:0]  tx_reg, ty_reg, tx_next, ty_next;
    logic signed [SUM_W-1:0]  base_x, base_y, cx, sy, sx, cy;
    logic [ANGLE_BITS-1:0]    sum_theta_reg;

    assign cx = SUM_W'(pcx_reg);
    assign sy = SUM_W'(psy_reg);
    assign sx = SUM_W'(psx_reg);
    assign cy = SUM_W'(pcy_reg);

    always_comb begin
        if (mul_side_reg.invert) begin
            base_x  = '0;
            base_y  = '0;
            tx_next = base_x - cx - sy;
            ty_next = base_y + sx - cy;
        end else begin
            base_x  = SUM_W'(mul_side_reg.ax) <<< TRIG_FRAC;
            base_y  = SUM_W'(mul_side_reg.ay) <<< TRIG_FRAC;
            tx_next = base_x + cx - sy;
            ty_next = base_y + sx + cy;
        end
    end

    assign sum_ready = !sum_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && mul_valid_reg) begin
            tx_reg        <= tx_next;
            ty_reg        <= ty_next;
            sum_theta_reg <= mul_side_reg.theta;
        end
    end

    // ---------------- round, saturate, output register ----------------
    logic                    out_valid_reg;
    logic [M_DATA_W-1:0]     out_data_reg, out_data_next;
    logic                    out_sat_reg, out_sat_next;
    logic signed [SUM_W-1:0] half, tx_rnd, ty_rnd;
    logic signed [RND_W-1:0] rx, ry;
    logic signed [POS_W-1:0] rx_sat, ry_sat;
    logic                    ovf_x, ovf_y;

    assign half   = SUM_W'(1) <<< (TRIG_FRAC - 1);
    assign tx_rnd = tx_reg + half;
    assign ty_rnd = ty_reg + half;
    assign rx     = tx_rnd[SUM_W-1:TRIG_FRAC];
    assign ry     = ty_rnd[SUM_W-1:TRIG_FRAC];

    // out of range when the bits above the 32-bit sign are not all sign copies
    assign ovf_x = !((&rx[RND_W-1:POS_W-1]) || !(|rx[RND_W-1:POS_W-1]));
    assign ovf_y = !((&ry[RND_W-1:POS_W-1]) || !(|ry[RND_W-1:POS_W-1]));

    always_comb begin
        if (ovf_x) begin
            rx_sat = rx[RND_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            rx_sat = rx[POS_W-1:0];
        end
        if (ovf_y) begin
            ry_sat = ry[RND_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            ry_sat = ry[POS_W-1:0];
        end
        out_data_next = {sum_theta_reg, ry_sat, rx_sat};
        out_sat_next  = ovf_x || ovf_y;
    end

    assign out_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && sum_valid_reg) begin
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

FILE: rtl/ppci_cordic_stage.sv
// One registered CORDIC rotation step with its own valid/ready slot.
// Depends on ppci_pkg for the vector and side-band types and the atan table.
module ppci_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ppci_pkg::cordic_t in_vec,
    input  ppci_pkg::side_t   in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output ppci_pkg::cordic_t out_vec,
    output ppci_pkg::side_t   out_side
);
    import ppci_pkg::*;

    logic                     valid_reg;
    cordic_t                  vec_reg, vec_next;
    side_t                    side_reg;
    logic signed [TRIG_W-1:0] x_in, y_in, dx, dy;
    logic signed [Z_W-1:0]    z_in, step;

    assign x_in = in_vec.x;
    assign y_in = in_vec.y;
    assign z_in = in_vec.z;
    assign dx   = y_in >>> STAGE;
    assign dy   = x_in >>> STAGE;
    assign step = $signed({1'b0, ATAN_TABLE[STAGE]});

    always_comb begin
        vec_next      = in_vec;
        if (!z_in[Z_W-1]) begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = z_in - step;
        end else begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = z_in + step;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

FILE: test/planar_pose_compose_invert_test.sv
// Self-checking bench for planar_pose_compose_invert: directed and random pose streams.
// Bit-exact pose predictor (CORDIC, Q2.30 rotate, round, clip); needs ppci_pkg and the RTL.
`timescale 1ns / 1ps

module planar_pose_compose_invert_test;
    import ppci_pkg::*;

    typedef enum logic {
        ACT_COMPOSE = 1'b0,
        ACT_INVERT  = 1'b1
    } action_e;

    typedef struct packed {
        action_e                 action;
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic [ANGLE_BITS-1:0]   at;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
        logic [ANGLE_BITS-1:0]   bt;
    } pose_req_t;

    typedef struct packed {
        logic signed [POS_W-1:0] rx;
        logic signed [POS_W-1:0] ry;
        logic [ANGLE_BITS-1:0]   rtheta;
        logic                    clipped;
    } pose_res_t;

    localparam int ROT_STEPS = TRIG_STAGES_DEF;
    localparam int LATENCY   = TRIG_STAGES_DEF + 4;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
    // atan(2^-i) as 32-bit binary angles
    localparam logic [0:15][31:0] ROT_STEP_ANGLE = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    pose_res_t expected_poses[$];
    int        mismatches  = 0;
    int        burst_left  = 0;
    int        n_sent      = 0;
    int        n_compose   = 0;
    int        n_invert    = 0;
    int        n_clipped   = 0;

    planar_pose_compose_invert i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic void heading_trig(input logic [ANGLE_BITS-1:0] th,
                                         output longint cs, output longint sn);
        logic [31:0] ang;
        logic [31:0] biased;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        ang    = {th, 16'h0000};
        biased = ang + 32'h4000_0000;
        flip   = biased[31];
        // fold the left half plane onto the right one, negate at the end
        if (flip) ang = ang ^ 32'h8000_0000;
        z = longint'($signed(ang));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ROT_STEP_ANGLE[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ROT_STEP_ANGLE[i]);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic logic signed [POS_W-1:0] round_clip(input longint t, inout logic hit);
        longint r;
        r = (t + 64'sd536870912) >>> 30;
        if (r > 64'sd2147483647) begin
            hit = 1'b1;
            return POS_MAX;
        end
        if (r < -64'sd2147483648) begin
            hit = 1'b1;
            return POS_MIN;
        end
        return r[POS_W-1:0];
    endfunction

    function automatic pose_res_t predict_pose(input pose_req_t q);
        longint    cs;
        longint    sn;
        longint    tx;
        longint    ty;
        longint    ax;
        longint    ay;
        longint    bx;
        longint    by;
        logic      hit;
        pose_res_t r;
        heading_trig(q.at, cs, sn);
        ax  = longint'(q.ax);
        ay  = longint'(q.ay);
        bx  = longint'(q.bx);
        by  = longint'(q.by);
        hit = 1'b0;
        if (q.action == ACT_COMPOSE) begin
            tx       = (ax <<< 30) + cs * bx - sn * by;
            ty       = (ay <<< 30) + sn * bx + cs * by;
            r.rtheta = q.at + q.bt;
        end else begin
            tx       = -(cs * ax + sn * ay);
            ty       = sn * ax - cs * ay;
            r.rtheta = 16'h0000 - q.at;
        end
        r.rx      = round_clip(tx, hit);
        r.ry      = round_clip(ty, hit);
        r.clipped = hit;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic signed [POS_W-1:0] random_position();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 4) return $signed($urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000);
        if (kind <= 7) return $signed($urandom);
        if (kind == 8) begin
            case ($urandom_range(0, 3))
                0: return POS_MAX;
                1: return POS_MIN;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        // magnitude at least 2^30, close to clipping
        return $signed({($urandom_range(0, 1) != 0) ? 2'b01 : 2'b10, 30'($urandom)});
    endfunction

    function automatic logic [ANGLE_BITS-1:0] random_heading();
        logic [ANGLE_BITS-1:0] base;
        if ($urandom_range(0, 9) < 7) return 16'($urandom);
        // within one step of a quadrant boundary
        base = {2'($urandom_range(0, 3)), 14'h0000};
        return base + 16'($urandom_range(0, 2)) - 16'd1;
    endfunction

    function automatic pose_req_t make_pose(action_e act,
                                            logic signed [POS_W-1:0] ax,
                                            logic signed [POS_W-1:0] ay,
                                            logic [ANGLE_BITS-1:0] at,
                                            logic signed [POS_W-1:0] bx,
                                            logic signed [POS_W-1:0] by,
                                            logic [ANGLE_BITS-1:0] bt);
        pose_req_t q;
        q.action = act;
        q.ax = ax;
        q.ay = ay;
        q.at = at;
        q.bx = bx;
        q.by = by;
        q.bt = bt;
        return q;
    endfunction

    // one transfer on the input side; bursts of random length with random gaps
    task automatic send_pose(input pose_req_t q);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tdata  <= {q.bt, q.by, q.bx, q.at, q.ay, q.ax};
        s_tuser  <= q.action;
        s_tvalid <= 1'b1;
        burst_left--;
        do @(posedge aclk); while (!s_tready);
        expected_poses.push_back(predict_pose(q));
        n_sent++;
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    endtask

    // ---------------- tests ----------------

    task automatic test_quadrant_headings();
        logic [ANGLE_BITS-1:0] heads [8];
        heads = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                  16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
        foreach (heads[i])
            send_pose(make_pose(ACT_COMPOSE, 32'sh0001_8000, -32'sh0002_4000, heads[i],
                                32'sh0001_0000, 32'sh0000_8000, 16'h1234));
        send_pose(make_pose(ACT_INVERT, 32'sh0003_0000, -32'sh0001_0000, 16'h2AAA,
                            32'sd0, 32'sd0, 16'h0000));
    endtask

    task automatic test_heading_wrap();
        send_pose(make_pose(ACT_COMPOSE, 32'sd0, 32'sd0, 16'hFFFF, 32'sd0, 32'sd0, 16'h0002));
        send_pose(make_pose(ACT_COMPOSE, -32'sd1, -32'sd1, 16'h8000, -32'sd1, -32'sd1,
                            16'h8000));
        send_pose(make_pose(ACT_INVERT, 32'sh0001_0000, 32'sd0, 16'h0000, 32'sd0, 32'sd0,
                            16'h0000));
        send_pose(make_pose(ACT_INVERT, 32'sd0, 32'sh0001_0000, 16'h0001, 32'sd0, 32'sd0,
                            16'h0000));
    endtask

    task automatic test_position_clipping();
        send_pose(make_pose(ACT_COMPOSE, POS_MAX, POS_MAX, 16'h0000, POS_MAX, POS_MAX,
                            16'hFFFF));
        send_pose(make_pose(ACT_COMPOSE, POS_MIN, POS_MIN, 16'h0000, POS_MIN, POS_MIN,
                            16'h0000));
        send_pose(make_pose(ACT_COMPOSE, POS_MAX, POS_MIN, 16'h2000, POS_MAX, POS_MAX,
                            16'h0000));
        send_pose(make_pose(ACT_INVERT, POS_MIN, POS_MIN, 16'h0000, 32'sd0, 32'sd0, 16'h0000));
        send_pose(make_pose(ACT_INVERT, POS_MAX, POS_MAX, 16'h8000, 32'sd0, 32'sd0, 16'h0000));
    endtask

    // invert must not see pose B: same A with opposite B patterns
    task automatic test_invert_ignores_b();
        send_pose(make_pose(ACT_INVERT, 32'sh1234_5678, -32'sh0765_4321, 16'h5A5A,
                            -32'sd1, -32'sd1, 16'hFFFF));
        send_pose(make_pose(ACT_INVERT, 32'sh1234_5678, -32'sh0765_4321, 16'h5A5A,
                            32'sd0, 32'sd0, 16'h0000));
    endtask

    task automatic test_random_poses(input int count);
        pose_req_t q;
        for (int n = 0; n < count; n++) begin
            q = make_pose(($urandom_range(0, 1) != 0) ? ACT_INVERT : ACT_COMPOSE,
                          random_position(), random_position(), random_heading(),
                          random_position(), random_position(), random_heading());
            send_pose(q);
        end
    endtask

    // ---------------- result side ----------------

    // receiver stall pattern: four modes that rotate in turn
    initial begin
        int cyc;
        cyc = 0;
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            case ((cyc / 256) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ((cyc % 7) >= 3);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
            cyc++;
        end
    end

    always @(posedge aclk) begin
        pose_res_t want;
        pose_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.rx      = m_tdata[31:0];
            got.ry      = m_tdata[63:32];
            got.rtheta  = m_tdata[79:64];
            got.clipped = m_tuser;
            if (expected_poses.size() == 0) begin
                report_mismatch("unexpected transfer, r_x", 0, got.rx);
            end else begin
                want = expected_poses.pop_front();
                if (got.rx !== want.rx) report_mismatch("r_x", want.rx, got.rx);
                if (got.ry !== want.ry) report_mismatch("r_y", want.ry, got.ry);
                if (got.rtheta !== want.rtheta)
                    report_mismatch("r_theta", want.rtheta, got.rtheta);
                if (got.clipped !== want.clipped)
                    report_mismatch("saturated", want.clipped, got.clipped);
                if (want.clipped) n_clipped++;
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            if (s_tuser == ACT_INVERT) n_invert++;
            else n_compose++;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_COMPOSE;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_quadrant_headings();
        test_heading_wrap();
        test_position_clipping();
        test_invert_ignores_b();
        test_random_poses(1800);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge aclk);
        repeat (LATENCY + 16) @(posedge aclk);

        $display("covered %0d transfers: %0d compose, %0d invert, %0d with clipped position",
                 n_sent, n_compose, n_invert, n_clipped);
        if (mismatches == 0)
            $display("[planar_pose_compose_invert] OK");
        else
            $display("[planar_pose_compose_invert] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_poses.size());
        $display("[planar_pose_compose_invert] ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/ppci_pkg.sv
rtl/ppci_cordic_stage.sv
rtl/planar_pose_compose_invert.sv
test/planar_pose_compose_invert_test.sv
